// ----- rtl/owbm_pkg.sv -----
// Shared types, codes and constants for the one-wire bus master.
package owbm_pkg;

   // Field widths
   localparam int MODE_W      = 3;
   localparam int DATA_W      = 8;
   localparam int TIME_W      = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int BIT_IDX_W   = 3;
   localparam int PHASE_W     = 2;

   // Item modes; a command's mode is also its command code
   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
   localparam logic [MODE_W-1:0] CMD_IDLE   = 3'd0;
   localparam logic [MODE_W-1:0] CMD_RESET  = 3'd1;
   localparam logic [MODE_W-1:0] CMD_WBIT   = 3'd2;
   localparam logic [MODE_W-1:0] CMD_RBIT   = 3'd3;
   localparam logic [MODE_W-1:0] CMD_WBYTE  = 3'd4;
   localparam logic [MODE_W-1:0] CMD_RBYTE  = 3'd5;

   // Slot phases
   localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LAST   = 2'd2;

   // Last bit of a byte
   localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_W1_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_W1_REC    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_W0_LOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_W0_REC    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RD_WAIT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RD_REC    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RST_LOW   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PRES_WAIT = 3'd7;

   // Fixed timings (parameter defaults)
   localparam logic [TIME_W-1:0] RESET_RECOVERY_US_DEF = 10'd410;
   localparam logic [TIME_W-1:0] READ_START_US_DEF     = 10'd1;

   typedef struct packed {
      logic [TIME_W-1:0] write_one_low_us;
      logic [TIME_W-1:0] write_one_recovery_us;
      logic [TIME_W-1:0] write_zero_low_us;
      logic [TIME_W-1:0] write_zero_recovery_us;
      logic [TIME_W-1:0] read_sample_wait_us;
      logic [TIME_W-1:0] read_recovery_us;
      logic [TIME_W-1:0] reset_low_us;
      logic [TIME_W-1:0] presence_wait_us;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      write_one_low_us:       10'd6,
      write_one_recovery_us:  10'd64,
      write_zero_low_us:      10'd60,
      write_zero_recovery_us: 10'd10,
      read_sample_wait_us:    10'd9,
      read_recovery_us:       10'd55,
      reset_low_us:           10'd480,
      presence_wait_us:       10'd70
   };

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence;
      logic [DATA_W-1:0] read_value;
      logic              rejected;
   } rsp_type;

endpackage

// ----- rtl/owbm_if.sv -----
// Valid/ready channel interfaces for command/tick beats and result beats.
interface owbm_req_if;
   import owbm_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [DATA_W-1:0] data;
   logic              line_level;

   modport source (output valid, output mode, output data, output line_level, input ready);
   modport sink   (input valid, input mode, input data, input line_level, output ready);
endinterface

interface owbm_rsp_if;
   import owbm_pkg::*;

   logic              valid;
   logic              ready;
   logic              drive_low;
   logic              busy_res;
   logic              done_res;
   logic              presence;
   logic [DATA_W-1:0] read_value;
   logic              rejected;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output read_value, output rejected, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input read_value, input rejected, output ready);
endinterface

// ----- rtl/one_wire_bus_master.sv -----
// One-wire bus master: command sequencer driven by one-microsecond tick beats.
// Every request beat (a command or a one-microsecond tick) is handled at the edge
// that accepts it: the sequencer state and the result register update together,
// so one beat per cycle is sustained while the result channel is ready. The result
// register is the only stage; a new beat is taken whenever that register is empty or
// its beat is being taken in the same cycle, so each result appears in the cycle after
// its request beat. Bus timing is counted in tick beats, not clock cycles.
module one_wire_bus_master #(
   parameter logic [owbm_pkg::TIME_W-1:0] RESET_RECOVERY_US = owbm_pkg::RESET_RECOVERY_US_DEF,
   parameter logic [owbm_pkg::TIME_W-1:0] READ_START_US     = owbm_pkg::READ_START_US_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   owbm_req_if.sink                           req_bus,
   owbm_rsp_if.source                         rsp_bus,
   input  logic                               csr_write_en,
   input  logic [owbm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [owbm_pkg::TIME_W-1:0]        csr_write_data
);
   import owbm_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [MODE_W-1:0]    cmd_ff, cmd_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [TIME_W-1:0]    timer_ff, timer_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [DATA_W-1:0]    shift_ff, shift_in;
   logic                 pres_ff, pres_in;
   logic [DATA_W-1:0]    latch_ff, latch_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic                 drive;
   logic                 done;
   logic                 rej;
   logic [PHASE_W-1:0]   phase_next;
   logic [PHASE_W-1:0]   phase_count;

   // Phase length for a command, phase and data bit; zero stretches to one tick
   function automatic logic [TIME_W-1:0] phase_len(input logic [MODE_W-1:0]  cmd,
                                                   input logic [PHASE_W-1:0] ph,
                                                   input logic               one,
                                                   input cfg_type            cfg);
      logic [TIME_W-1:0] len;
      case (cmd)
         CMD_RESET: begin
            if (ph == PH_FIRST)     len = cfg.reset_low_us;
            else if (ph == PH_WAIT) len = cfg.presence_wait_us;
            else                    len = RESET_RECOVERY_US;
         end
         CMD_WBIT, CMD_WBYTE: begin
            if (ph == PH_FIRST) len = one ? cfg.write_one_low_us : cfg.write_zero_low_us;
            else len = one ? cfg.write_one_recovery_us : cfg.write_zero_recovery_us;
         end
         default: begin
            if (ph == PH_FIRST)     len = READ_START_US;
            else if (ph == PH_WAIT) len = cfg.read_sample_wait_us;
            else                    len = cfg.read_recovery_us;
         end
      endcase
      return (len == '0) ? TIME_W'(1) : len;
   endfunction

   // Take a beat when the result register is empty or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_W1_LOW:    cfg_in.write_one_low_us       = csr_write_data;
            REG_W1_REC:    cfg_in.write_one_recovery_us  = csr_write_data;
            REG_W0_LOW:    cfg_in.write_zero_low_us      = csr_write_data;
            REG_W0_REC:    cfg_in.write_zero_recovery_us = csr_write_data;
            REG_RD_WAIT:   cfg_in.read_sample_wait_us    = csr_write_data;
            REG_RD_REC:    cfg_in.read_recovery_us       = csr_write_data;
            REG_RST_LOW:   cfg_in.reset_low_us           = csr_write_data;
            REG_PRES_WAIT: cfg_in.presence_wait_us       = csr_write_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   assign phase_next  = phase_ff + PHASE_W'(1);
   assign phase_count = (cmd_ff == CMD_WBIT || cmd_ff == CMD_WBYTE) ? PHASE_W'(2) : PHASE_W'(3);

   // Advance the sequencer for one beat
   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      latch_in = latch_ff;
      drive    = 1'b0;
      done     = 1'b0;
      rej      = 1'b0;
      if (accept) begin
         case (req_bus.mode) inside
            MODE_TICK: begin
               if (cmd_ff != CMD_IDLE) begin
                  drive = (phase_ff == PH_FIRST);
                  if (timer_ff > TIME_W'(1)) begin
                     timer_in = timer_ff - TIME_W'(1);
                  end else begin
                     // Sample at the end of the wait phase
                     if (phase_ff == PH_WAIT) begin
                        if (cmd_ff == CMD_RESET) pres_in = ~req_bus.line_level;
                        else if (cmd_ff == CMD_RBIT) shift_in = DATA_W'(req_bus.line_level);
                        else if (cmd_ff == CMD_RBYTE)
                           shift_in = {req_bus.line_level, shift_ff[DATA_W-1:1]};
                     end
                     if (phase_next < phase_count) begin
                        phase_in = phase_next;
                        timer_in = phase_len(cmd_ff, phase_next, shift_in[0], cfg_ff);
                     end else if ((cmd_ff == CMD_WBYTE || cmd_ff == CMD_RBYTE)
                                  && bit_ff < LAST_BIT) begin
                        // Next bit of the byte
                        bit_in   = bit_ff + BIT_IDX_W'(1);
                        if (cmd_ff == CMD_WBYTE) shift_in = shift_ff >> 1;
                        phase_in = PH_FIRST;
                        timer_in = phase_len(cmd_ff, PH_FIRST, shift_in[0], cfg_ff);
                     end else begin
                        // Command complete
                        if (cmd_ff == CMD_RBIT || cmd_ff == CMD_RBYTE) latch_in = shift_in;
                        cmd_in   = CMD_IDLE;
                        phase_in = PH_FIRST;
                        timer_in = '0;
                        bit_in   = '0;
                        done     = 1'b1;
                     end
                  end
               end
            end
            [CMD_RESET:CMD_RBYTE]: begin
               if (cmd_ff != CMD_IDLE) begin
                  rej   = 1'b1;
                  drive = (phase_ff == PH_FIRST);
               end else begin
                  cmd_in   = req_bus.mode;
                  phase_in = PH_FIRST;
                  bit_in   = '0;
                  if (req_bus.mode == CMD_WBIT)       shift_in = DATA_W'(req_bus.data[0]);
                  else if (req_bus.mode == CMD_WBYTE) shift_in = req_bus.data;
                  else                                shift_in = '0;
                  timer_in = phase_len(req_bus.mode, PH_FIRST, req_bus.data[0], cfg_ff);
                  drive    = 1'b1;
               end
            end
            default: begin
               drive = (cmd_ff != CMD_IDLE) && (phase_ff == PH_FIRST);
            end
         endcase
      end
   end

   // Build the result beat and hold it until taken
   always_comb begin
      rsp_in.drive_low  = drive;
      rsp_in.busy_res   = (cmd_in != CMD_IDLE);
      rsp_in.done_res   = done;
      rsp_in.presence   = pres_in;
      rsp_in.read_value = latch_in;
      rsp_in.rejected   = rej;
      if (accept)              rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)  rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         cmd_ff       <= CMD_IDLE;
         phase_ff     <= PH_FIRST;
         timer_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         pres_ff      <= 1'b0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         cmd_ff       <= cmd_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         pres_ff      <= pres_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   // Drive the result channel
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.drive_low  = rsp_ff.drive_low;
   assign rsp_bus.busy_res   = rsp_ff.busy_res;
   assign rsp_bus.done_res   = rsp_ff.done_res;
   assign rsp_bus.presence   = rsp_ff.presence;
   assign rsp_bus.read_value = rsp_ff.read_value;
   assign rsp_bus.rejected   = rsp_ff.rejected;

   // Idle sequencer leaves no phase, timer or bit count behind
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      cmd_ff == CMD_IDLE |-> phase_ff == PH_FIRST && timer_ff == '0 && bit_ff == '0)
      else $error("idle sequencer holds stale phase state");

   // A running sequence always has time left in its phase
   a_timer_live: assert property (@(posedge clock) disable iff (reset)
      cmd_ff != CMD_IDLE |-> timer_ff != '0)
      else $error("active phase with zero timer");

   // Write slots have only two phases
   a_write_phases: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_WBIT || cmd_ff == CMD_WBYTE) |-> phase_ff != PH_LAST)
      else $error("write slot entered a third phase");

   // A completing beat leaves the master idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res && !rsp_ff.rejected)
      else $error("done reported while still busy or rejected");

   // A rejected command only happens while busy
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rejected |-> rsp_ff.busy_res)
      else $error("command rejected while idle");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the one-wire bus master: command, tick and timing register traffic.
module tb;
   import owbm_pkg::*;

   // Modes above the last command; the block ignores them
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int RANDOM_BEATS = 300;
   localparam int BEATS_PER_SETTING = 80;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [TIME_W-1:0] csr_write_data;

   owbm_req_if req_if ();
   owbm_rsp_if rsp_if ();

   one_wire_bus_master u_top (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Predicted sequencer state and timing registers
   cfg_type timing;
   logic [MODE_W-1:0] cur_cmd;
   logic [PHASE_W-1:0] cur_phase;
   logic [TIME_W-1:0] phase_left;
   logic [BIT_IDX_W-1:0] bit_pos;
   logic [DATA_W-1:0] shift_reg;
   logic pres_flag;
   logic [DATA_W-1:0] read_latch;

   rsp_type status_due[$];
   int mismatches = 0;
   int useful_beats = 0;

   // Pacing state for the two sides
   bit send_calm = 1'b0;
   int send_run = 0;
   bit recv_calm = 1'b0;
   int recv_run = 0;
   int recv_stall = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Pause length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_pause(inout bit calm, inout int run_len);
      int r;
      run_len++;
      if (run_len % 40 == 0)
         calm = ($urandom_range(0, 3) == 0);
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(4, 12);
   endfunction

   // Length of the phase about to start, zero stretched to one tick
   function automatic logic [TIME_W-1:0] slot_length();
      logic [TIME_W-1:0] len;
      case (cur_cmd)
         CMD_RESET: begin
            len = (cur_phase == PH_FIRST) ? timing.reset_low_us :
                  (cur_phase == PH_WAIT)  ? timing.presence_wait_us : RESET_RECOVERY_US_DEF;
         end
         CMD_WBIT, CMD_WBYTE: begin
            if (cur_phase == PH_FIRST)
               len = shift_reg[0] ? timing.write_one_low_us : timing.write_zero_low_us;
            else
               len = shift_reg[0] ? timing.write_one_recovery_us
                                  : timing.write_zero_recovery_us;
         end
         default: begin
            len = (cur_phase == PH_FIRST) ? READ_START_US_DEF :
                  (cur_phase == PH_WAIT)  ? timing.read_sample_wait_us : timing.read_recovery_us;
         end
      endcase
      return (len == '0) ? TIME_W'(1) : len;
   endfunction

   // Advance the predicted master by one beat and return the status it reports
   function automatic rsp_type advance_master(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                                              logic line);
      rsp_type r;
      logic is_wr;
      r = '0;
      is_wr = (cur_cmd == CMD_WBIT || cur_cmd == CMD_WBYTE);
      if (mode == MODE_TICK) begin
         if (cur_cmd != CMD_IDLE) begin
            r.drive_low = (cur_phase == PH_FIRST);
            if (phase_left > 1) begin
               phase_left--;
            end else begin
               // sample at the end of the wait phase
               if (cur_phase == PH_WAIT) begin
                  case (cur_cmd)
                     CMD_RESET: pres_flag = ~line;
                     CMD_RBIT:  shift_reg = {{(DATA_W-1){1'b0}}, line};
                     CMD_RBYTE: shift_reg = {line, shift_reg[DATA_W-1:1]};
                     default: ;
                  endcase
               end
               if (cur_phase != (is_wr ? PH_WAIT : PH_LAST)) begin
                  cur_phase++;
                  phase_left = slot_length();
               end else if ((cur_cmd == CMD_WBYTE || cur_cmd == CMD_RBYTE) &&
                            bit_pos != LAST_BIT) begin
                  bit_pos++;
                  if (cur_cmd == CMD_WBYTE)
                     shift_reg = shift_reg >> 1;
                  cur_phase = PH_FIRST;
                  phase_left = slot_length();
               end else begin
                  if (cur_cmd == CMD_RBIT || cur_cmd == CMD_RBYTE)
                     read_latch = shift_reg;
                  cur_cmd = CMD_IDLE;
                  cur_phase = PH_FIRST;
                  phase_left = '0;
                  bit_pos = '0;
                  r.done_res = 1'b1;
               end
            end
         end
      end else begin
         if (mode <= CMD_RBYTE) begin
            if (cur_cmd != CMD_IDLE) begin
               r.rejected = 1'b1;
            end else begin
               cur_cmd = mode;
               cur_phase = PH_FIRST;
               bit_pos = '0;
               if (mode == CMD_WBIT)
                  shift_reg = {{(DATA_W-1){1'b0}}, data[0]};
               else if (mode == CMD_WBYTE)
                  shift_reg = data;
               else
                  shift_reg = '0;
               phase_left = slot_length();
            end
         end
         r.drive_low = (cur_cmd != CMD_IDLE && cur_phase == PH_FIRST);
      end
      r.busy_res = (cur_cmd != CMD_IDLE);
      r.presence = pres_flag;
      r.read_value = read_latch;
      return r;
   endfunction

   // Offer one beat after a random gap and record its predicted status
   task automatic send_beat(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data, logic line);
      int gap;
      logic was_busy;
      rsp_type due;
      @(negedge clock);
      gap = pick_pause(send_calm, send_run);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.mode = mode;
      req_if.data = data;
      req_if.line_level = line;
      do @(posedge clock); while (!req_if.ready);
      was_busy = (cur_cmd != CMD_IDLE);
      due = advance_master(mode, data, line);
      status_due.push_back(due);
      if (!(due.rejected || mode > CMD_RBYTE || (mode == MODE_TICK && !was_busy)))
         useful_beats++;
   endtask

   // Drop valid and hold until every predicted status has come back
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (status_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [TIME_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      case (idx)
         REG_W1_LOW:    timing.write_one_low_us = value;
         REG_W1_REC:    timing.write_one_recovery_us = value;
         REG_W0_LOW:    timing.write_zero_low_us = value;
         REG_W0_REC:    timing.write_zero_recovery_us = value;
         REG_RD_WAIT:   timing.read_sample_wait_us = value;
         REG_RD_REC:    timing.read_recovery_us = value;
         REG_RST_LOW:   timing.reset_low_us = value;
         REG_PRES_WAIT: timing.presence_wait_us = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Drain, then load all eight timing registers
   task automatic program_timing(cfg_type c);
      wait_idle();
      write_reg(REG_W1_LOW, c.write_one_low_us);
      write_reg(REG_W1_REC, c.write_one_recovery_us);
      write_reg(REG_W0_LOW, c.write_zero_low_us);
      write_reg(REG_W0_REC, c.write_zero_recovery_us);
      write_reg(REG_RD_WAIT, c.read_sample_wait_us);
      write_reg(REG_RD_REC, c.read_recovery_us);
      write_reg(REG_RST_LOW, c.reset_low_us);
      write_reg(REG_PRES_WAIT, c.presence_wait_us);
   endtask

   // Mostly short phases, so all but reset commands finish in a few dozen ticks
   function automatic cfg_type random_timing();
      cfg_type c;
      for (int i = 0; i < 8; i++)
         c[i*TIME_W +: TIME_W] = TIME_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 24)
                                                                     : $urandom_range(0, 3));
      return c;
   endfunction

   // Tick until the command completes; read_bits and answer set the sampled levels
   task automatic finish_sequence(logic [DATA_W-1:0] read_bits, logic answer, int noise_pct);
      logic line;
      while (cur_cmd != CMD_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            // command or spare mode while busy
            send_beat(MODE_W'($urandom_range(CMD_RESET, MODE_SPARE_HI)),
                      DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            line = 1'($urandom_range(0, 1));
            if (cur_phase == PH_WAIT && phase_left <= 1)
               line = (cur_cmd == CMD_RESET) ? ~answer : read_bits[bit_pos];
            send_beat(MODE_TICK, DATA_W'($urandom_range(0, 255)), line);
         end
      end
   endtask

   task automatic run_command(logic [MODE_W-1:0] op, logic [DATA_W-1:0] data,
                              logic [DATA_W-1:0] read_bits, logic answer, int noise_pct);
      send_beat(op, data, 1'($urandom_range(0, 1)));
      finish_sequence(read_bits, answer, noise_pct);
   endtask

   // Bit commands at reset timing, both data values and both sampled levels
   task automatic test_default_timing();
      run_command(CMD_WBIT, 8'h01, 8'h00, 1'b0, 0);
      run_command(CMD_WBIT, 8'hFE, 8'h00, 1'b0, 0);
      run_command(CMD_RBIT, 8'h00, 8'h01, 1'b0, 0);
      run_command(CMD_RBIT, 8'h00, 8'h00, 1'b0, 0);
   endtask

   // Ticks and spare modes while idle, then every mode while busy
   task automatic test_ignored_beats();
      send_beat(MODE_TICK, 8'h00, 1'b0);
      send_beat(MODE_TICK, 8'hFF, 1'b1);
      send_beat(MODE_SPARE_LO, 8'h55, 1'b0);
      send_beat(MODE_SPARE_HI, 8'hAA, 1'b1);
      send_beat(CMD_WBIT, 8'h01, 1'b0);
      for (int m = CMD_RESET; m <= MODE_SPARE_HI; m++)
         send_beat(MODE_W'(m), DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      finish_sequence(8'h00, 1'b0, 0);
   endtask

   // All timing registers at zero, each such phase stretched to one tick
   task automatic test_zero_timing();
      program_timing('0);
      run_command(CMD_WBIT, 8'h00, 8'h00, 1'b0, 0);
      run_command(CMD_WBIT, 8'h01, 8'h00, 1'b0, 0);
      run_command(CMD_RBIT, 8'h00, 8'hFF, 1'b0, 0);
      run_command(CMD_WBYTE, 8'hFF, 8'h00, 1'b0, 0);
      run_command(CMD_RBYTE, 8'h00, 8'hC3, 1'b0, 0);
      run_command(CMD_RESET, 8'h00, 8'h00, 1'b1, 10);
   endtask

   // Random commands with random content under a fresh short setting every few dozen beats
   task automatic test_random_traffic();
      int stop_at;
      int setting_end;
      int r;
      logic [MODE_W-1:0] op;
      stop_at = useful_beats + RANDOM_BEATS;
      while (useful_beats < stop_at) begin
         program_timing(random_timing());
         setting_end = useful_beats + BEATS_PER_SETTING;
         while (useful_beats < setting_end) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send_beat(($urandom_range(0, 2) == 0) ? MODE_TICK
                            : MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                         DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               op = (r < 11) ? CMD_RESET : MODE_W'($urandom_range(CMD_WBIT, CMD_RBYTE));
               run_command(op, DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 5);
            end
         end
      end
   endtask

   // Result side: ready with random stalls
   always @(negedge clock) begin
      if (recv_stall > 0) begin
         rsp_if.ready = 1'b0;
         recv_stall--;
      end else begin
         rsp_if.ready = 1'b1;
         recv_stall = pick_pause(recv_calm, recv_run);
      end
   end

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Compare each result beat with the oldest predicted status
   always @(posedge clock) begin : check_status
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (status_due.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with no status expected", $time);
         end else begin
            want = status_due.pop_front();
            check_field("drive_low", want.drive_low, rsp_if.drive_low);
            check_field("busy_res", want.busy_res, rsp_if.busy_res);
            check_field("done_res", want.done_res, rsp_if.done_res);
            check_field("presence", want.presence, rsp_if.presence);
            check_field("read_value", want.read_value, rsp_if.read_value);
            check_field("rejected", want.rejected, rsp_if.rejected);
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.mode = MODE_TICK;
      req_if.data = '0;
      req_if.line_level = 1'b0;
      timing = CFG_RESET;
      cur_cmd = CMD_IDLE;
      cur_phase = PH_FIRST;
      phase_left = '0;
      bit_pos = '0;
      shift_reg = '0;
      pres_flag = 1'b0;
      read_latch = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_timing();
      test_ignored_beats();
      test_zero_timing();
      test_random_traffic();

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("one_wire_bus_master test passed");
      else
         $display("one_wire_bus_master test failed");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5000000;
      $display("one_wire_bus_master test failed");
      $finish;
   end

endmodule
